FILE: sv/tgc_pkg.sv
// Shared types and constants for the touch gesture classifier.
package tgc_pkg;

    localparam int CFG_W      = 12;
    localparam int MS_W       = 16;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 5;
    localparam int REG_IDX_W  = 3;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_LONG_PRESS  = 3'd0,
        REG_DEBOUNCE    = 3'd1,
        REG_SCREEN_H    = 3'd2,
        REG_BOTTOM_ZONE = 3'd3,
        REG_TOP_ZONE    = 3'd4,
        REG_SWIPE_DIST  = 3'd5
    } t_reg_idx;

    typedef enum logic {
        OP_SAMPLE = 1'b0,
        OP_WAKE   = 1'b1
    } t_op;

    typedef enum logic [2:0] {
        GEST_NONE  = 3'd0,
        GEST_LONG  = 3'd1,
        GEST_UP    = 3'd2,
        GEST_DOWN  = 3'd3,
        GEST_TAP   = 3'd4
    } t_gesture;

    typedef struct packed {
        logic [MS_W-1:0]  hold_limit;
        logic [MS_W-1:0]  tap_holdoff;
        logic [CFG_W-1:0] screen_height;
        logic [CFG_W-1:0] bottom_zone;
        logic [CFG_W-1:0] top_zone;
        logic [CFG_W-1:0] swipe_travel;
    } t_cfg;

    localparam logic [MS_W-1:0]  RST_LONG_PRESS  = 16'd800;
    localparam logic [MS_W-1:0]  RST_DEBOUNCE    = 16'd200;
    localparam logic [CFG_W-1:0] RST_SCREEN_H    = 12'd240;
    localparam logic [CFG_W-1:0] RST_BOTTOM_ZONE = 12'd40;
    localparam logic [CFG_W-1:0] RST_TOP_ZONE    = 12'd40;
    localparam logic [CFG_W-1:0] RST_SWIPE_DIST  = 12'd50;

endpackage

FILE: sv/touch_gesture_classifier_core.sv
// Top level of the touch gesture classifier: input register, decision step, result register.
//
//  Channel  Dir  Payload                                      Transfer when
//  s        in   tuser: operation; tdata: sample fields       i_s_tvalid & o_s_tready
//  m        out  tdata: gesture, pos_x, pos_y                 o_m_tvalid & i_m_tready
//  apb      in   six config registers at 4*index              psel & penable & pwrite
//
// One sample per cycle sustained while the result side does not stall; a result passes from
// the input register through the decision logic into the result register.
// The input stage keeps accepting while a result waits, as long as the result register
// frees up in the same cycle; a stalled result holds both stages.
// Synchronous active-low reset clears valids, touch state and config to defaults.
module touch_gesture_classifier_core #(
    parameter int COORD_BITS = 12,
    parameter int TIME_BITS  = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // tdata, low to high: read_ok, touch_points, sample_x, sample_y, now_ms, zero fill
    input  logic [((9+2*COORD_BITS+TIME_BITS+7)/8)*8-1:0] i_s_tdata,
    // tuser: operation
    input  logic [0:0]                      i_s_tuser,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // tdata, low to high: gesture, pos_x, pos_y, zero fill
    output logic [((3+2*COORD_BITS+7)/8)*8-1:0] o_m_tdata,
    input  logic                            i_psel,
    input  logic                            i_penable,
    input  logic                            i_pwrite,
    input  logic [tgc_pkg::APB_ADDR_W-1:0]  i_paddr,
    input  logic [tgc_pkg::APB_DATA_W-1:0]  i_pwdata,
    output logic [tgc_pkg::APB_DATA_W-1:0]  o_prdata,
    output logic                            o_pready
);

    localparam int IN_RAW  = 9 + 2*COORD_BITS + TIME_BITS;
    localparam int IN_W    = ((IN_RAW + 7) / 8) * 8;
    localparam int OUT_RAW = 3 + 2*COORD_BITS;
    localparam int OUT_W   = ((OUT_RAW + 7) / 8) * 8;
    localparam int X_LO    = 9;
    localparam int Y_LO    = 9 + COORD_BITS;
    localparam int T_LO    = 9 + 2*COORD_BITS;

    tgc_pkg::t_cfg         w_cfg;
    logic                  r_in_valid;
    logic [IN_RAW-1:0]     r_in_data;
    logic                  r_in_op;
    logic                  r_out_valid;
    logic [OUT_RAW-1:0]    r_out_data;
    logic                  w_s_xfer;
    logic                  w_adv;
    tgc_pkg::t_gesture     w_gesture;
    logic [COORD_BITS-1:0] w_pos_x;
    logic [COORD_BITS-1:0] w_pos_y;

    tgc_apb_regs u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (i_psel),
        .i_penable (i_penable),
        .i_pwrite  (i_pwrite),
        .i_paddr   (i_paddr),
        .i_pwdata  (i_pwdata),
        .o_prdata  (o_prdata),
        .o_pready  (o_pready),
        .o_cfg     (w_cfg)
    );

    // advance the held sample when the result register is free or draining
    assign w_adv      = r_in_valid & (~r_out_valid | i_m_tready);
    assign o_s_tready = ~r_in_valid | w_adv;
    assign w_s_xfer   = i_s_tvalid & o_s_tready;

    tgc_step #(
        .COORD_BITS (COORD_BITS),
        .TIME_BITS  (TIME_BITS)
    ) u_step (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_adv          (w_adv),
        .i_cfg          (w_cfg),
        .i_op           (r_in_op),
        .i_read_ok      (r_in_data[0]),
        .i_touch_points (r_in_data[8:1]),
        .i_sample_x     (r_in_data[X_LO +: COORD_BITS]),
        .i_sample_y     (r_in_data[Y_LO +: COORD_BITS]),
        .i_now_ms       (r_in_data[T_LO +: TIME_BITS]),
        .o_gesture      (w_gesture),
        .o_pos_x        (w_pos_x),
        .o_pos_y        (w_pos_y)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_s_xfer) begin
                r_in_valid <= 1'b1;
            end else if (w_adv) begin
                r_in_valid <= 1'b0;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s_xfer) begin
            r_in_data <= i_s_tdata[IN_RAW-1:0];
            r_in_op   <= i_s_tuser[0];
        end
        if (w_adv) begin
            r_out_data <= {w_pos_y, w_pos_x, w_gesture};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(OUT_W-OUT_RAW){1'b0}}, r_out_data};

    // upper fill bits of the input are unused
    logic w_unused_fill;
    assign w_unused_fill = ^{1'b0, i_s_tdata[IN_W-1:IN_RAW]};

endmodule

FILE: sv/tgc_apb_regs.sv
// APB configuration register file for the touch gesture classifier.
module tgc_apb_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_psel,
    input  logic                              i_penable,
    input  logic                              i_pwrite,
    input  logic [tgc_pkg::APB_ADDR_W-1:0]    i_paddr,
    input  logic [tgc_pkg::APB_DATA_W-1:0]    i_pwdata,
    output logic [tgc_pkg::APB_DATA_W-1:0]    o_prdata,
    output logic                              o_pready,
    output tgc_pkg::t_cfg                     o_cfg
);

    tgc_pkg::t_cfg r_cfg;
    tgc_pkg::t_cfg n_cfg;
    logic [tgc_pkg::REG_IDX_W-1:0] w_idx;
    logic w_wr;

    assign w_idx    = i_paddr[tgc_pkg::APB_ADDR_W-1:2];
    assign w_wr     = i_psel & i_penable & i_pwrite;
    assign o_pready = 1'b1;
    assign o_cfg    = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (w_wr) begin
            unique case (w_idx)
                tgc_pkg::REG_LONG_PRESS:  n_cfg.hold_limit    = i_pwdata[tgc_pkg::MS_W-1:0];
                tgc_pkg::REG_DEBOUNCE:    n_cfg.tap_holdoff   = i_pwdata[tgc_pkg::MS_W-1:0];
                tgc_pkg::REG_SCREEN_H:    n_cfg.screen_height = i_pwdata[tgc_pkg::CFG_W-1:0];
                tgc_pkg::REG_BOTTOM_ZONE: n_cfg.bottom_zone   = i_pwdata[tgc_pkg::CFG_W-1:0];
                tgc_pkg::REG_TOP_ZONE:    n_cfg.top_zone      = i_pwdata[tgc_pkg::CFG_W-1:0];
                tgc_pkg::REG_SWIPE_DIST:  n_cfg.swipe_travel  = i_pwdata[tgc_pkg::CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            tgc_pkg::REG_LONG_PRESS:
                o_prdata = {{(tgc_pkg::APB_DATA_W-tgc_pkg::MS_W){1'b0}}, r_cfg.hold_limit};
            tgc_pkg::REG_DEBOUNCE:
                o_prdata = {{(tgc_pkg::APB_DATA_W-tgc_pkg::MS_W){1'b0}}, r_cfg.tap_holdoff};
            tgc_pkg::REG_SCREEN_H:
                o_prdata = {{(tgc_pkg::APB_DATA_W-tgc_pkg::CFG_W){1'b0}}, r_cfg.screen_height};
            tgc_pkg::REG_BOTTOM_ZONE:
                o_prdata = {{(tgc_pkg::APB_DATA_W-tgc_pkg::CFG_W){1'b0}}, r_cfg.bottom_zone};
            tgc_pkg::REG_TOP_ZONE:
                o_prdata = {{(tgc_pkg::APB_DATA_W-tgc_pkg::CFG_W){1'b0}}, r_cfg.top_zone};
            tgc_pkg::REG_SWIPE_DIST:
                o_prdata = {{(tgc_pkg::APB_DATA_W-tgc_pkg::CFG_W){1'b0}}, r_cfg.swipe_travel};
            default:
                o_prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.hold_limit    <= tgc_pkg::RST_LONG_PRESS;
            r_cfg.tap_holdoff   <= tgc_pkg::RST_DEBOUNCE;
            r_cfg.screen_height <= tgc_pkg::RST_SCREEN_H;
            r_cfg.bottom_zone   <= tgc_pkg::RST_BOTTOM_ZONE;
            r_cfg.top_zone      <= tgc_pkg::RST_TOP_ZONE;
            r_cfg.swipe_travel  <= tgc_pkg::RST_SWIPE_DIST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

FILE: sv/tgc_step.sv
// Touch state registers and the per-sample gesture decision logic.
module tgc_step #(
    parameter int COORD_BITS = 12,
    parameter int TIME_BITS  = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_adv,
    input  tgc_pkg::t_cfg          i_cfg,
    input  logic                   i_op,
    input  logic                   i_read_ok,
    input  logic [7:0]             i_touch_points,
    input  logic [COORD_BITS-1:0]  i_sample_x,
    input  logic [COORD_BITS-1:0]  i_sample_y,
    input  logic [TIME_BITS-1:0]   i_now_ms,
    output tgc_pkg::t_gesture      o_gesture,
    output logic [COORD_BITS-1:0]  o_pos_x,
    output logic [COORD_BITS-1:0]  o_pos_y
);

    // signed compare width covering both coordinates and 12-bit config values
    localparam int SW = ((COORD_BITS > tgc_pkg::CFG_W) ? COORD_BITS : tgc_pkg::CFG_W) + 2;

    logic                  r_was_touched, n_was_touched;
    logic [TIME_BITS-1:0]  r_press_start_time, n_press_start_time;
    logic [TIME_BITS-1:0]  r_last_tap_time, n_last_tap_time;
    logic                  r_long_press_done, n_long_press_done;
    logic [COORD_BITS-1:0] r_held_x, n_held_x;
    logic [COORD_BITS-1:0] r_held_y, n_held_y;
    logic [COORD_BITS-1:0] r_press_start_y, n_press_start_y;
    tgc_pkg::t_gesture     w_gesture;

    logic                  w_touched;
    logic [TIME_BITS-1:0]  w_held_ms;
    logic [TIME_BITS-1:0]  w_since_tap;
    logic signed [SW-1:0]  w_dy;
    logic signed [SW-1:0]  w_bound;
    logic signed [SW-1:0]  w_dist;
    logic signed [SW-1:0]  w_start_y;
    logic                  w_at_bottom;
    logic                  w_at_top;

    assign w_touched   = i_read_ok & (i_touch_points != 8'd0);
    assign w_held_ms   = i_now_ms - r_press_start_time;
    assign w_since_tap = i_now_ms - r_last_tap_time;
    assign w_start_y   = $signed({{(SW-COORD_BITS){1'b0}}, r_press_start_y});
    assign w_dy        = w_start_y - $signed({{(SW-COORD_BITS){1'b0}}, r_held_y});
    assign w_bound     = $signed({{(SW-tgc_pkg::CFG_W){1'b0}}, i_cfg.screen_height})
                       - $signed({{(SW-tgc_pkg::CFG_W){1'b0}}, i_cfg.bottom_zone});
    assign w_dist      = $signed({{(SW-tgc_pkg::CFG_W){1'b0}}, i_cfg.swipe_travel});
    assign w_at_bottom = w_start_y > w_bound;
    assign w_at_top    = w_start_y < $signed({{(SW-tgc_pkg::CFG_W){1'b0}}, i_cfg.top_zone});

    always_comb begin
        n_was_touched      = r_was_touched;
        n_press_start_time = r_press_start_time;
        n_last_tap_time    = r_last_tap_time;
        n_long_press_done  = r_long_press_done;
        n_held_x           = r_held_x;
        n_held_y           = r_held_y;
        n_press_start_y    = r_press_start_y;
        w_gesture          = tgc_pkg::GEST_NONE;
        if (i_op == tgc_pkg::OP_WAKE) begin
            n_was_touched      = 1'b1;
            n_long_press_done  = 1'b0;
            n_press_start_time = '0;
        end else begin
            if (w_touched) begin
                n_held_x = i_sample_x;
                n_held_y = i_sample_y;
                if (!r_was_touched) begin
                    n_press_start_time = i_now_ms;
                    n_press_start_y    = i_sample_y;
                    n_long_press_done  = 1'b0;
                end else if (!r_long_press_done &&
                             w_held_ms > {{(TIME_BITS-tgc_pkg::MS_W){1'b0}},
                                          i_cfg.hold_limit}) begin
                    n_long_press_done = 1'b1;
                    w_gesture         = tgc_pkg::GEST_LONG;
                end
            end else if (r_was_touched && !r_long_press_done) begin
                // release: swipe checks take priority over tap
                priority if (w_at_bottom && (w_dy > w_dist)) begin
                    w_gesture = tgc_pkg::GEST_UP;
                end else if (w_at_top && (w_dy < -w_dist)) begin
                    w_gesture = tgc_pkg::GEST_DOWN;
                end else if (w_since_tap > {{(TIME_BITS-tgc_pkg::MS_W){1'b0}},
                                             i_cfg.tap_holdoff}) begin
                    n_last_tap_time = i_now_ms;
                    w_gesture       = tgc_pkg::GEST_TAP;
                end else begin
                    w_gesture = tgc_pkg::GEST_NONE;
                end
            end
            n_was_touched = w_touched;
        end
    end

    assign o_gesture = w_gesture;
    assign o_pos_x   = n_held_x;
    assign o_pos_y   = n_held_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_was_touched      <= 1'b0;
            r_press_start_time <= '0;
            r_last_tap_time    <= '0;
            r_long_press_done  <= 1'b0;
            r_held_x           <= '0;
            r_held_y           <= '0;
            r_press_start_y    <= '0;
        end else if (i_adv) begin
            r_was_touched      <= n_was_touched;
            r_press_start_time <= n_press_start_time;
            r_last_tap_time    <= n_last_tap_time;
            r_long_press_done  <= n_long_press_done;
            r_held_x           <= n_held_x;
            r_held_y           <= n_held_y;
            r_press_start_y    <= n_press_start_y;
        end
    end

endmodule

FILE: tb/touch_gesture_classifier_core_tb.sv
// Testbench for the touch gesture classifier: directed and random touch traffic.
`timescale 1ns / 100ps

module touch_gesture_classifier_core_tb;

    localparam int WATCHDOG_LIMIT = 3000;

    // Packed so that read_ok lands in bit 0 of tdata
    typedef struct packed {
        logic [31:0] now_ms;
        logic [11:0] y;
        logic [11:0] x;
        logic [7:0]  points;
        logic        read_ok;
    } t_touch_sample;

    typedef struct packed {
        tgc_pkg::t_gesture gesture;
        logic [11:0]       x;
        logic [11:0]       y;
    } t_gesture_result;

    class t_gesture_scoreboard;
        tgc_pkg::t_cfg     cfg;
        bit                was_touched;
        bit                long_done;
        logic [31:0]       start_time;
        logic [31:0]       last_tap;
        logic [11:0]       held_x;
        logic [11:0]       held_y;
        logic [11:0]       start_y;
        t_gesture_result   pending_results[$];
        int                errors;

        function new();
            cfg.hold_limit    = tgc_pkg::RST_LONG_PRESS;
            cfg.tap_holdoff   = tgc_pkg::RST_DEBOUNCE;
            cfg.screen_height = tgc_pkg::RST_SCREEN_H;
            cfg.bottom_zone   = tgc_pkg::RST_BOTTOM_ZONE;
            cfg.top_zone      = tgc_pkg::RST_TOP_ZONE;
            cfg.swipe_travel  = tgc_pkg::RST_SWIPE_DIST;
            was_touched = 1'b0;
            long_done   = 1'b0;
            start_time  = '0;
            last_tap    = '0;
            held_x      = '0;
            held_y      = '0;
            start_y     = '0;
            errors      = 0;
        endfunction

        function void set_reg(tgc_pkg::t_reg_idx idx, logic [31:0] val);
            case (idx)
                tgc_pkg::REG_LONG_PRESS:  cfg.hold_limit    = val[15:0];
                tgc_pkg::REG_DEBOUNCE:    cfg.tap_holdoff   = val[15:0];
                tgc_pkg::REG_SCREEN_H:    cfg.screen_height = val[11:0];
                tgc_pkg::REG_BOTTOM_ZONE: cfg.bottom_zone   = val[11:0];
                tgc_pkg::REG_TOP_ZONE:    cfg.top_zone      = val[11:0];
                tgc_pkg::REG_SWIPE_DIST:  cfg.swipe_travel  = val[11:0];
                default: ;
            endcase
        endfunction

        function void note_input(tgc_pkg::t_op op, t_touch_sample smp);
            tgc_pkg::t_gesture g;
            bit                touched;
            int                dy;
            int                bound;
            int                travel;
            logic [31:0]       dt;
            t_gesture_result   res;
            g = tgc_pkg::GEST_NONE;
            if (op == tgc_pkg::OP_WAKE) begin
                was_touched = 1'b1;
                long_done   = 1'b0;
                start_time  = '0;
            end else begin
                touched = smp.read_ok && (smp.points != 0);
                if (touched) begin
                    held_x = smp.x;
                    held_y = smp.y;
                    dt = smp.now_ms - start_time;
                    if (!was_touched) begin
                        start_time = smp.now_ms;
                        start_y    = smp.y;
                        long_done  = 1'b0;
                    end else if (!long_done && dt > cfg.hold_limit) begin
                        long_done = 1'b1;
                        g = tgc_pkg::GEST_LONG;
                    end
                end else if (was_touched && !long_done) begin
                    dy     = int'(start_y) - int'(held_y);
                    bound  = int'(cfg.screen_height) - int'(cfg.bottom_zone);
                    travel = int'(cfg.swipe_travel);
                    dt     = smp.now_ms - last_tap;
                    if (int'(start_y) > bound && dy > travel) begin
                        g = tgc_pkg::GEST_UP;
                    end else if (start_y < cfg.top_zone && dy < -travel) begin
                        g = tgc_pkg::GEST_DOWN;
                    end else if (dt > cfg.tap_holdoff) begin
                        last_tap = smp.now_ms;
                        g = tgc_pkg::GEST_TAP;
                    end
                end
                was_touched = touched;
            end
            res.gesture = g;
            res.x       = held_x;
            res.y       = held_y;
            pending_results.push_back(res);
        endfunction

        function void check_result(logic [31:0] tdata);
            t_gesture_result want;
            if (pending_results.size() == 0) begin
                $error("result with no pending expectation: tdata=%h", tdata);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            if (tdata[2:0] !== want.gesture) begin
                $error("gesture: expected %0d, got %0d", want.gesture, tdata[2:0]);
                errors++;
            end
            if (tdata[14:3] !== want.x) begin
                $error("pos_x: expected %0d, got %0d", want.x, tdata[14:3]);
                errors++;
            end
            if (tdata[26:15] !== want.y) begin
                $error("pos_y: expected %0d, got %0d", want.y, tdata[26:15]);
                errors++;
            end
        endfunction

        function int pending();
            return pending_results.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata   = '0;
    logic [0:0]  s_tuser   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;
    logic        psel      = 1'b0;
    logic        penable   = 1'b0;
    logic        pwrite    = 1'b0;
    logic [4:0]  paddr     = '0;
    logic [31:0] pwdata    = '0;
    logic [31:0] prdata;
    logic        pready;

    t_gesture_scoreboard gesture_sb;
    bit                tx_free_run = 1'b0;
    bit                rx_free_run = 1'b0;
    int                items_sent  = 0;
    int                rx_stall_left = 0;
    int                idle_cycles = 0;
    logic [31:0]       ms_clock;

    touch_gesture_classifier_core u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .i_psel     (psel),
        .i_penable  (penable),
        .i_pwrite   (pwrite),
        .i_paddr    (paddr),
        .i_pwdata   (pwdata),
        .o_prdata   (prdata),
        .o_pready   (pready)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Receiver: random stalls, mostly short, a few long
    always @(posedge clk) begin
        if (rx_stall_left > 0) begin
            rx_stall_left--;
            m_tready <= 1'b0;
        end else if (!rx_free_run && $urandom_range(0, 99) < 25) begin
            rx_stall_left = ($urandom_range(0, 9) == 0) ? int'($urandom_range(10, 40))
                                                        : int'($urandom_range(0, 2));
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge clk) begin
        if (rst_n && m_tvalid && m_tready) begin
            gesture_sb.check_result(m_tdata);
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = int'($urandom_range(0, 99));
        if (tx_free_run || r < 60) return 0;
        if (r < 90) return int'($urandom_range(1, 3));
        if (r < 97) return int'($urandom_range(4, 8));
        return int'($urandom_range(10, 40));
    endfunction

    function automatic logic [31:0] pick_delta();
        int r;
        r = int'($urandom_range(0, 99));
        if (r < 70) return $urandom_range(0, 400);
        if (r < 90) return $urandom_range(0, 3000);
        if (r < 98) return $urandom_range(0, 70000);
        return $urandom();
    endfunction

    function automatic logic [11:0] clamp_coord(int v);
        if (v < 0) return 12'd0;
        if (v > 4095) return 12'd4095;
        return v[11:0];
    endfunction

    function automatic t_touch_sample mk_sample(bit ok, logic [7:0] pts, logic [11:0] x,
                                                logic [11:0] y, logic [31:0] t);
        t_touch_sample smp;
        smp.read_ok = ok;
        smp.points  = pts;
        smp.x       = x;
        smp.y       = y;
        smp.now_ms  = t;
        return smp;
    endfunction

    task automatic send_item(tgc_pkg::t_op op, t_touch_sample smp);
        int gap;
        gap = pick_gap();
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {7'd0, smp};
        do @(posedge clk); while (!s_tready);
        gesture_sb.note_input(op, smp);
        items_sent++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic touch(logic [7:0] pts, logic [11:0] x, logic [11:0] y, logic [31:0] t);
        send_item(tgc_pkg::OP_SAMPLE, mk_sample(1'b1, pts, x, y, t));
    endtask

    task automatic lift(bit ok, logic [7:0] pts, logic [31:0] t);
        send_item(tgc_pkg::OP_SAMPLE,
                  mk_sample(ok, ok ? 8'd0 : pts, 12'($urandom), 12'($urandom), t));
    endtask

    task automatic wake();
        send_item(tgc_pkg::OP_WAKE, mk_sample(1'($urandom), 8'($urandom), 12'($urandom),
                                              12'($urandom), $urandom));
    endtask

    // Hold off the sender until every pending result has come back
    task automatic wait_drain();
        s_tvalid <= 1'b0;
        while (gesture_sb.pending() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic apb_write(tgc_pkg::t_reg_idx idx, logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        gesture_sb.set_reg(idx, val);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apply_setting(int kind);
        logic [15:0] lp, deb;
        logic [11:0] sh, bz, tz, travel;
        case (kind)
            0: begin
                lp = 16'd0; deb = 16'd0; sh = 12'd0; bz = 12'd0; tz = 12'd0; travel = 12'd0;
            end
            1: begin
                lp = 16'hFFFF; deb = 16'hFFFF;
                sh = 12'hFFF; bz = 12'hFFF; tz = 12'hFFF; travel = 12'hFFF;
            end
            2: begin
                // bottom zone taller than the screen: every start counts as bottom
                lp = 16'($urandom_range(0, 1500)); deb = 16'($urandom_range(0, 500));
                sh = 12'($urandom_range(0, 50)); bz = 12'($urandom_range(100, 4095));
                tz = 12'($urandom_range(0, 200)); travel = 12'($urandom_range(0, 100));
            end
            3: begin
                lp = 16'($urandom); deb = 16'($urandom);
                sh = 12'($urandom); bz = 12'($urandom); tz = 12'($urandom);
                travel = 12'($urandom);
            end
            default: begin
                lp = 16'($urandom_range(0, 1500)); deb = 16'($urandom_range(0, 500));
                sh = 12'($urandom_range(100, 500)); bz = 12'($urandom_range(0, 100));
                tz = 12'($urandom_range(0, 100)); travel = 12'($urandom_range(0, 100));
            end
        endcase
        wait_drain();
        apb_write(tgc_pkg::REG_LONG_PRESS,  {16'($urandom_range(0, 65535)), lp});
        apb_write(tgc_pkg::REG_DEBOUNCE,    {16'($urandom_range(0, 65535)), deb});
        apb_write(tgc_pkg::REG_SCREEN_H,    {20'd0, sh});
        apb_write(tgc_pkg::REG_BOTTOM_ZONE, {20'd0, bz});
        apb_write(tgc_pkg::REG_TOP_ZONE,    {20'd0, tz});
        apb_write(tgc_pkg::REG_SWIPE_DIST,  {20'd0, travel});
    endtask

    // One press, a few held samples and a release, shaped toward one gesture
    task automatic gesture_burst();
        int          kind, holds, bound, travel, target;
        logic [11:0] y0, y1;
        logic [31:0] t0;
        logic [7:0]  pts;
        kind   = int'($urandom_range(0, 4));
        bound  = int'(gesture_sb.cfg.screen_height) - int'(gesture_sb.cfg.bottom_zone);
        travel = int'(gesture_sb.cfg.swipe_travel);
        holds  = int'($urandom_range(1, 5));
        case (kind)
            0: begin
                y0 = clamp_coord(bound
                                 + int'($urandom_range(0, gesture_sb.cfg.bottom_zone + 2)) - 1);
                y1 = clamp_coord(int'(y0) - travel - int'($urandom_range(0, 4)) + 2);
            end
            1: begin
                y0 = clamp_coord(int'($urandom_range(0, gesture_sb.cfg.top_zone + 1)) - 1);
                y1 = clamp_coord(int'(y0) + travel + int'($urandom_range(0, 4)) - 2);
            end
            default: begin
                y0 = 12'($urandom);
                y1 = ($urandom_range(0, 1) == 0) ? y0 : 12'($urandom);
            end
        endcase
        target = int'(gesture_sb.cfg.hold_limit) + int'($urandom_range(0, 4)) - 2;
        if (target < 0) target = 0;
        pts = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(1, 255)) : 8'($urandom_range(1, 3));
        t0 = ms_clock;
        touch(pts, 12'($urandom), y0, ms_clock);
        for (int k = 0; k < holds; k++) begin
            if (kind == 3 && k == holds - 1) begin
                ms_clock = t0 + 32'(target);
            end else if (kind == 2) begin
                ms_clock += $urandom_range(0, 100);
            end else begin
                ms_clock += pick_delta();
            end
            touch(pts, 12'($urandom), (k == holds - 1) ? y1 : 12'($urandom_range(y0, y1)),
                  ms_clock);
        end
        ms_clock += pick_delta();
        lift(1'($urandom_range(0, 1)), 8'($urandom), ms_clock);
    endtask

    task automatic run_random(int n_items, bit with_pause);
        int first, r;
        first = items_sent;
        while (items_sent - first < n_items) begin
            r = int'($urandom_range(0, 99));
            if (with_pause && items_sent - first > n_items / 2) begin
                wait_drain();
                with_pause = 1'b0;
            end
            if (r < 75) begin
                gesture_burst();
            end else if (r < 83) begin
                wake();
            end else begin
                if ($urandom_range(0, 1) == 0) ms_clock += pick_delta();
                send_item(tgc_pkg::OP_SAMPLE,
                          mk_sample(1'($urandom), 8'($urandom), 12'($urandom), 12'($urandom),
                                    ($urandom_range(0, 3) == 0) ? $urandom : ms_clock));
            end
        end
    endtask

    initial begin : stimulus
        gesture_sb = new();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: bottom bound 200, zones 40, travel 50, long press 800, debounce 200
        send_item(tgc_pkg::OP_SAMPLE, mk_sample(1'b0, 8'd255, 12'hFFF, 12'hFFF, 32'hFFFF_FFFF));
        wake();
        lift(1'b1, 8'd0, 32'd1000);                 // release after wake: stale start, tap
        touch(8'd1, 12'd0, 12'd230, 32'd2000);
        touch(8'd1, 12'hFFF, 12'd100, 32'd2100);
        lift(1'b1, 8'd0, 32'd2200);                 // swipe up
        touch(8'd2, 12'd0, 12'd10, 32'd3000);
        touch(8'd2, 12'd5, 12'd200, 32'd3100);
        lift(1'b0, 8'd7, 32'd3200);                 // swipe down, failed read as release
        touch(8'd1, 12'd7, 12'd120, 32'd4000);
        lift(1'b1, 8'd0, 32'd4050);                 // tap
        touch(8'd1, 12'd7, 12'd120, 32'd4100);
        lift(1'b1, 8'd0, 32'd4150);                 // inside debounce window, nothing
        touch(8'd255, 12'hFFF, 12'd0, 32'd5000);
        touch(8'd255, 12'hFFF, 12'd0, 32'd5800);    // exactly at threshold, nothing
        touch(8'd255, 12'hFFF, 12'd0, 32'd5801);    // long press
        touch(8'd255, 12'hFFF, 12'd0, 32'd6000);
        lift(1'b1, 8'd0, 32'd6100);                 // no tap after a long press
        touch(8'd1, 12'd300, 12'd300, 32'hFFFF_FF00);
        touch(8'd1, 12'd300, 12'd300, 32'h0000_0300);  // elapsed wraps past zero
        lift(1'b0, 8'd255, 32'h0000_0400);
        touch(8'd3, 12'd1, 12'd2, 32'd7000);
        wake();                                     // start time cleared mid-press
        touch(8'd3, 12'd1, 12'd2, 32'd7000);
        lift(1'b1, 8'd0, 32'd7100);

        ms_clock = 32'd10000;
        run_random(110, 1'b0);

        for (int phase = 0; phase < 7; phase++) begin
            apply_setting((phase < 4) ? phase : 4);
            tx_free_run = ($urandom_range(0, 3) == 0);
            rx_free_run = ($urandom_range(0, 3) == 0);
            run_random(105, phase == 5);
        end

        wait_drain();
        repeat (10) @(posedge clk);
        if (gesture_sb.errors == 0 && gesture_sb.pending() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

FILE: files.f
sv/tgc_pkg.sv
sv/tgc_apb_regs.sv
sv/tgc_step.sv
sv/touch_gesture_classifier_core.sv
tb/touch_gesture_classifier_core_tb.sv
